### rtl/idpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpr_pkg: shared types and constants
// Register codes, controller states and the bundles passed between the
// configuration block, the controller and the datapath.
// ----------------------------------------------------------------------------
package idpr_pkg;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register index codes (byte address bits [3:2]).
    localparam logic [1:0] REG_OUTPUT_OFFSET = 2'd0;
    localparam logic [1:0] REG_INPUT_OFFSET  = 2'd1;
    localparam logic [1:0] REG_CLAMP_LOW     = 2'd2;
    localparam logic [1:0] REG_CLAMP_HIGH    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIAS,
        S_MUL,
        S_RND,
        S_SHR,
        S_CLAMP
    } t_state;

    typedef struct packed {
        logic signed [7:0] output_offset;
        logic signed [8:0] input_offset;
        logic signed [7:0] clamp_low;
        logic signed [7:0] clamp_high;
    } t_cfg;

    typedef struct packed {
        logic mac;        // add the product of the transferred pair
        logic capture;    // latch bias, multiplier and shift of a last element
        logic bias_shift; // add bias, apply left shift, clear accumulator
        logic mul;        // full 32x32 product
        logic rnd;        // rounding doubling high half
        logic shr;        // rounding right shift
        logic load_out;   // offset, clamp and load the output register
    } t_dp_cmd;

endpackage

### rtl/idpr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpr_cfg: configuration registers
// APB-style register file holding the offsets and the clamp bounds.
// ----------------------------------------------------------------------------
module idpr_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [idpr_pkg::APB_AW-1:0] paddr,
    input  logic [idpr_pkg::APB_DW-1:0] pwdata,
    output logic [idpr_pkg::APB_DW-1:0] prdata,
    output idpr_pkg::t_cfg             o_cfg
);
    import idpr_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_offset <= 8'sd0;
            r_cfg.input_offset  <= 9'sd0;
            r_cfg.clamp_low     <= -8'sd128;
            r_cfg.clamp_high    <= 8'sd127;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_OUTPUT_OFFSET: r_cfg.output_offset <= pwdata[7:0];
                REG_INPUT_OFFSET:  r_cfg.input_offset  <= pwdata[8:0];
                REG_CLAMP_LOW:     r_cfg.clamp_low     <= pwdata[7:0];
                REG_CLAMP_HIGH:    r_cfg.clamp_high    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OUTPUT_OFFSET: prdata = {{24{r_cfg.output_offset[7]}}, r_cfg.output_offset};
            REG_INPUT_OFFSET:  prdata = {{23{r_cfg.input_offset[8]}}, r_cfg.input_offset};
            REG_CLAMP_LOW:     prdata = {{24{r_cfg.clamp_low[7]}}, r_cfg.clamp_low};
            REG_CLAMP_HIGH:    prdata = {{24{r_cfg.clamp_high[7]}}, r_cfg.clamp_high};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/idpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpr_ctrl: sequence controller
// Accepts elements, steps the requantize stages after a last element and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module idpr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output idpr_pkg::t_dp_cmd   o_cmd
);
    import idpr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_xfer;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_xfer && i_in_last) n_state = S_BIAS;
            S_BIAS:  n_state = S_MUL;
            S_MUL:   n_state = S_RND;
            S_RND:   n_state = S_SHR;
            S_SHR:   n_state = S_CLAMP;
            S_CLAMP: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.mac     = in_xfer;
                o_cmd.capture = in_xfer & i_in_last;
            end
            S_BIAS:  o_cmd.bias_shift = 1'b1;
            S_MUL:   o_cmd.mul        = 1'b1;
            S_RND:   o_cmd.rnd        = 1'b1;
            S_SHR:   o_cmd.shr        = 1'b1;
            S_CLAMP: o_cmd.load_out   = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/idpr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpr_dp: multiply-accumulate and requantize datapath
// One MAC per element, then bias, shift, doubling high multiply, rounding
// shift, offset and clamp, one stage per command.
// ----------------------------------------------------------------------------
module idpr_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  idpr_pkg::t_dp_cmd        i_cmd,
    input  idpr_pkg::t_cfg           i_cfg,
    input  logic signed [7:0]        i_weight,
    input  logic signed [7:0]        i_activation,
    input  logic signed [31:0]       i_bias,
    input  logic signed [31:0]       i_multiplier,
    input  logic signed [5:0]        i_shift,
    output logic signed [7:0]        o_result
);
    import idpr_pkg::*;

    logic        [31:0] r_acc;
    logic        [31:0] r_bias;
    logic signed [31:0] r_mult;
    logic signed [5:0]  r_shift;
    logic signed [31:0] r_val;
    logic               r_sat;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_high;
    logic signed [32:0] r_shr;
    logic signed [7:0]  r_result;

    logic signed [9:0]  act_off;
    logic signed [17:0] mac_prod;
    logic        [31:0] acc_sum;
    logic        [4:0]  left_amt;
    logic        [31:0] biased;
    logic signed [63:0] prod_nudged;
    logic        [5:0]  right_amt;
    logic        [32:0] rs_mask;
    logic        [32:0] rs_rem;
    logic        [32:0] rs_thr;
    logic signed [32:0] rs_floor;
    logic signed [33:0] off_sum;
    logic signed [33:0] lo_bound;
    logic signed [33:0] hi_bound;
    logic signed [33:0] lo_clamped;
    logic signed [33:0] clamped;

    // Multiply-accumulate, wrapping modulo 2^32.
    assign act_off  = {{2{i_activation[7]}}, i_activation} +
                      {i_cfg.input_offset[8], i_cfg.input_offset};
    assign mac_prod = i_weight * act_off;
    assign acc_sum  = r_acc + {{14{mac_prod[17]}}, mac_prod};

    // Bias and left shift for a positive shift amount.
    assign left_amt = r_shift[5] ? 5'd0 : r_shift[4:0];
    assign biased   = r_acc + r_bias;

    // Truncation toward zero of (p + nudge) / 2^31 reduces to (p + 2^30) >>> 31
    // for both sign cases of the nudge.
    assign prod_nudged = r_prod + 64'sd1073741824;

    // Rounding right shift by 0 to 32 for a non-positive shift amount.
    assign right_amt = r_shift[5] ? (~r_shift + 6'd1) : 6'd0;
    assign rs_mask   = (33'd1 << right_amt) - 33'd1;
    assign rs_rem    = {r_high[31], r_high} & rs_mask;
    assign rs_thr    = (rs_mask >> 1) + {32'd0, r_high[31]};
    assign rs_floor  = $signed({r_high[31], r_high}) >>> right_amt;

    // Output offset at full precision, lower bound first, upper bound second.
    assign off_sum    = {r_shr[32], r_shr} +
                        {{26{i_cfg.output_offset[7]}}, i_cfg.output_offset};
    assign lo_bound   = {{26{i_cfg.clamp_low[7]}}, i_cfg.clamp_low};
    assign hi_bound   = {{26{i_cfg.clamp_high[7]}}, i_cfg.clamp_high};
    assign lo_clamped = (off_sum < lo_bound) ? lo_bound : off_sum;
    assign clamped    = (lo_clamped > hi_bound) ? hi_bound : lo_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.mac) begin
            r_acc <= acc_sum;
        end else if (i_cmd.bias_shift) begin
            r_acc <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bias  <= i_bias;
            r_mult  <= i_multiplier;
            r_shift <= i_shift;
        end
        if (i_cmd.bias_shift) begin
            r_val <= biased << left_amt;
        end
        if (i_cmd.mul) begin
            r_prod <= r_val * r_mult;
            r_sat  <= (r_val == 32'sh80000000) && (r_mult == 32'sh80000000);
        end
        if (i_cmd.rnd) begin
            r_high <= r_sat ? 32'sh7FFFFFFF : prod_nudged[62:31];
        end
        if (i_cmd.shr) begin
            r_shr <= rs_floor + {32'd0, (rs_rem > rs_thr)};
        end
        if (i_cmd.load_out) begin
            r_result <= clamped[7:0];
        end
    end

    assign o_result = r_result;

endmodule

### rtl/int8_dot_product_requantize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_dot_product_requantize: int8 dot product with per-channel requantize
// Accumulates weight * (activation + input offset) and, on the last element,
// adds bias, requantizes, offsets and clamps to one int8 result.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one weight and
// activation pair per transfer, plus the channel's bias, multiplier and
// shift, which are only looked at when i_last_element is set. The output
// channel (o_out_valid / i_out_ready) carries one int8 result per dot product.
// An element that is not last leaves the controller idle, so a dot product
// streams at one pair per clock through the single 8x10 multiply-accumulate.
// A last element holds the input off while the
// controller walks the requantize stages (bias and shift, 32x32 multiply,
// rounding high half, rounding right shift, offset and clamp); the result
// is loaded into the output register in the clamp stage, and each stage is
// one register apart.
// The result sits in an output register, so the next dot product starts
// while the result still waits; if the receiver stalls and a second result
// is ready, the block stays in its clamp stage until the register frees.
// Reset clears the accumulator, the output valid flag and the registers to
// their defaults. The user must write configuration over the APB-style port
// only while the block is idle (not enforced here); pready is always high.
// ----------------------------------------------------------------------------
module int8_dot_product_requantize (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [idpr_pkg::APB_AW-1:0]  paddr,
    input  logic [idpr_pkg::APB_DW-1:0]  pwdata,
    output logic [idpr_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // Input element channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [7:0]            i_weight,
    input  logic signed [7:0]            i_activation,
    input  logic signed [31:0]           i_bias,
    input  logic signed [31:0]           i_multiplier,
    input  logic signed [5:0]            i_shift,
    input  logic                         i_last_element,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [7:0]            o_result
);
    import idpr_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;

    // The register file never inserts wait states.
    assign pready = 1'b1;

    idpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // The controller decides which stage runs in each cycle; the datapath
    // only follows its commands.
    idpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_last_element),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    idpr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (cfg),
        .i_weight     (i_weight),
        .i_activation (i_activation),
        .i_bias       (i_bias),
        .i_multiplier (i_multiplier),
        .i_shift      (i_shift),
        .o_result     (o_result)
    );

endmodule

### rtl/idpr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idpr_chk: port-level checker
// Watches the top-level channels for sequencing slips and binds itself to
// the top level.
// ----------------------------------------------------------------------------
module idpr_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         i_last_element,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [7:0]            o_result
);

    // A last element starts the requantize sequence, so the input closes.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_element) |=> !o_in_ready)
        else $error("input ready right after a last element transfer");

    // A new result only appears at the end of the sequence, when input is closed.
    a_result_from_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised without a requantize sequence");

    // Reset empties the output register.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A waiting result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_result)))
        else $error("stalled result dropped or changed");

endmodule

bind int8_dot_product_requantize idpr_chk u_idpr_chk (.*);
